>>> rtl/qpf_pkg.sv
package qpf_pkg;

  // Widths are sized for full-scale 12-bit samples.
  localparam int SMP_W   = 12;
  localparam int NSMP    = 4;
  localparam int DOT_W   = 30;
  localparam int A_W     = 23;
  localparam int B_W     = 26;
  localparam int C_W     = 26;
  localparam int BM_W    = 25;
  localparam int AC_W    = A_W + C_W;
  localparam int BB_W    = 2 * B_W;
  localparam int NV_W    = 55;
  localparam int UV_W    = 54;
  localparam int DV_W    = 37;
  localparam int UT_W    = 32;
  localparam int DT_W    = 22;
  localparam int Q_W     = 24;
  localparam int PV_W    = 24;
  localparam int PT_W    = 16;
  localparam int CV_W    = 24;
  localparam int FIT_DET = 7568;
  localparam int TIME_SH = 7;
  localparam int VAL_SH  = 4;

  typedef logic [SMP_W-1:0]        smp_t;
  typedef logic signed [DOT_W-1:0] dot_t;
  typedef dot_t                    wvec_t [NSMP];

  localparam wvec_t W_A = '{30'sd212, -30'sd668, -30'sd148, 30'sd604};
  localparam wvec_t W_B = '{-30'sd2556, 30'sd4484, 30'sd1356, -30'sd3284};
  localparam wvec_t W_C = '{30'sd7564, 30'sd84, -30'sd140, 30'sd60};

  typedef logic signed [A_W-1:0] a_t;
  typedef logic signed [B_W-1:0] b_t;
  typedef logic signed [C_W-1:0] c_t;

  typedef struct packed {
    a_t a;
    b_t b;
    c_t c;
  } coef_t;

  typedef struct packed {
    logic flat;
    logic neg_v;
    logic neg_t;
    a_t   a;
  } side_t;

endpackage

>>> rtl/qpf_if.sv
interface qpf_in_if;
  logic                 valid;
  logic                 ready;
  logic [qpf_pkg::SMP_W-1:0] sample_t0;
  logic [qpf_pkg::SMP_W-1:0] sample_t5;
  logic [qpf_pkg::SMP_W-1:0] sample_t6;
  logic [qpf_pkg::SMP_W-1:0] sample_t7;

  modport source (output valid, sample_t0, sample_t5, sample_t6, sample_t7, input ready);
  modport sink   (input valid, sample_t0, sample_t5, sample_t6, sample_t7, output ready);
endinterface

interface qpf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [qpf_pkg::PV_W-1:0]  peak_value;
  logic signed [qpf_pkg::PT_W-1:0]  peak_time;
  logic signed [qpf_pkg::CV_W-1:0]  curvature;
  logic                             no_curvature;
  logic                             saturated;

  modport source (output valid, peak_value, peak_time, curvature, no_curvature, saturated,
                  input ready);
  modport sink   (input valid, peak_value, peak_time, curvature, no_curvature, saturated,
                  output ready);
endinterface

>>> rtl/quadratic_pulse_peak_fit.sv
// Least-squares parabola peak fit over four ADC samples at times 0, 5, 6, 7.
//
// in_chan carries one transaction per pulse: the four samples. out_chan
// returns one transaction per pulse: the peak height (4 fraction bits), the
// peak time (8 fraction bits), the scaled curvature and two flags. When the
// curvature is zero, no_curvature is set and the peak fields are zero.
// Peak fields that do not fit are clipped and flag saturated.
//
// The block is a single pipeline that accepts one transaction per clock
// while it is not stalled. One stage forms the fit coefficients, three form
// the products and rounded numerators, and the two quotients come from
// restoring dividers with one quotient bit per stage (24 bits plus a range
// check), followed by the output register.
//
// The pipeline advances whenever the output register is empty or being read.
// While out_chan is stalled with a result waiting, the pipeline holds and
// in_chan.ready is low; nothing is dropped or repeated. The whole pipeline
// holds as one, so bubbles inside it are not squeezed out during a stall.
// Reset clears all valid bits and holds in_chan.ready low; a transaction can
// be accepted in the first cycle after reset.
module quadratic_pulse_peak_fit #(
  parameter int ADC_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  qpf_in_if.sink     in_chan,
  qpf_out_if.source  out_chan
);

  localparam int DIV_LAT = qpf_pkg::Q_W + 1;
  localparam logic [qpf_pkg::Q_W-1:0] PV_POS_MAX = qpf_pkg::Q_W'((1 << (qpf_pkg::PV_W-1)) - 1);
  localparam logic [qpf_pkg::Q_W-1:0] PV_NEG_MAX = qpf_pkg::Q_W'(1 << (qpf_pkg::PV_W-1));
  localparam logic [qpf_pkg::Q_W-1:0] PT_POS_MAX = qpf_pkg::Q_W'((1 << (qpf_pkg::PT_W-1)) - 1);
  localparam logic [qpf_pkg::Q_W-1:0] PT_NEG_MAX = qpf_pkg::Q_W'(1 << (qpf_pkg::PT_W-1));

  logic                           en;
  qpf_pkg::smp_t                  smp [qpf_pkg::NSMP];
  logic                           v1;
  qpf_pkg::coef_t                 coef1;
  logic                           v4;
  logic [qpf_pkg::UV_W-1:0]       uv4;
  logic [qpf_pkg::DV_W-1:0]       dv4;
  logic [qpf_pkg::UT_W-1:0]       ut4;
  logic [qpf_pkg::DT_W-1:0]       dt4;
  qpf_pkg::side_t                 side4;
  qpf_pkg::side_t                 side_r [DIV_LAT];
  qpf_pkg::side_t                 side_q;
  logic                           qv_v, qt_v;
  logic [qpf_pkg::Q_W-1:0]        qv, qt;
  logic                           qv_ovf, qt_ovf;

  logic                           sat_v, sat_t;
  logic [qpf_pkg::Q_W-1:0]        pv_mag, pt_mag, pv_neg, pt_neg;
  logic signed [qpf_pkg::PV_W-1:0] pv_nxt;
  logic signed [qpf_pkg::PT_W-1:0] pt_nxt;
  logic signed [qpf_pkg::CV_W-1:0] cv_nxt;
  logic                           sat_nxt;

  logic                           out_v_r;
  logic signed [qpf_pkg::PV_W-1:0] pv_r;
  logic signed [qpf_pkg::PT_W-1:0] pt_r;
  logic signed [qpf_pkg::CV_W-1:0] cv_r;
  logic                           nc_r;
  logic                           sat_r;

  assign en            = !out_v_r || out_chan.ready;
  assign in_chan.ready = en && rst_n;

  assign smp[0] = in_chan.sample_t0;
  assign smp[1] = in_chan.sample_t5;
  assign smp[2] = in_chan.sample_t6;
  assign smp[3] = in_chan.sample_t7;

  qpf_coef #(.ADC_BITS(ADC_BITS)) u_coef (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (in_chan.valid),
    .smp    (smp),
    .v_r    (v1),
    .coef_r (coef1)
  );

  qpf_prod u_prod (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v1),
    .coef    (coef1),
    .v4_r    (v4),
    .uv_r    (uv4),
    .dv4_r   (dv4),
    .ut4_r   (ut4),
    .dt4_r   (dt4),
    .side4_r (side4)
  );

  qpf_div #(
    .NUM_W (qpf_pkg::UV_W),
    .DEN_W (qpf_pkg::DV_W),
    .Q_W   (qpf_pkg::Q_W)
  ) u_div_value (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (v4),
    .num   (uv4),
    .den   (dv4),
    .out_v (qv_v),
    .quo   (qv),
    .ovf   (qv_ovf)
  );

  qpf_div #(
    .NUM_W (qpf_pkg::UT_W),
    .DEN_W (qpf_pkg::DT_W),
    .Q_W   (qpf_pkg::Q_W)
  ) u_div_time (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (v4),
    .num   (ut4),
    .den   (dt4),
    .out_v (qt_v),
    .quo   (qt),
    .ovf   (qt_ovf)
  );

  // Signs, flags and curvature ride alongside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side4;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign side_q = side_r[DIV_LAT-1];

  // A negative result may reach one count further than a positive one.
  always_comb begin
    sat_v  = qv_ovf || (side_q.neg_v ? (qv > PV_NEG_MAX) : (qv > PV_POS_MAX));
    sat_t  = qt_ovf || (side_q.neg_t ? (qt > PT_NEG_MAX) : (qt > PT_POS_MAX));
    pv_mag = sat_v ? (side_q.neg_v ? PV_NEG_MAX : PV_POS_MAX) : qv;
    pt_mag = sat_t ? (side_q.neg_t ? PT_NEG_MAX : PT_POS_MAX) : qt;
    pv_neg = ~pv_mag + 1'b1;
    pt_neg = ~pt_mag + 1'b1;
    cv_nxt = qpf_pkg::CV_W'(side_q.a);
    if (side_q.flat) begin
      pv_nxt  = '0;
      pt_nxt  = '0;
      sat_nxt = 1'b0;
    end else begin
      pv_nxt  = side_q.neg_v ? pv_neg[qpf_pkg::PV_W-1:0] : pv_mag[qpf_pkg::PV_W-1:0];
      pt_nxt  = side_q.neg_t ? pt_neg[qpf_pkg::PT_W-1:0] : pt_mag[qpf_pkg::PT_W-1:0];
      sat_nxt = sat_v || sat_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= qv_v && qt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pv_r  <= pv_nxt;
      pt_r  <= pt_nxt;
      cv_r  <= cv_nxt;
      nc_r  <= side_q.flat;
      sat_r <= sat_nxt;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.peak_value   = pv_r;
  assign out_chan.peak_time    = pt_r;
  assign out_chan.curvature    = cv_r;
  assign out_chan.no_curvature = nc_r;
  assign out_chan.saturated    = sat_r;

  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.no_curvature |->
      out_chan.peak_value == '0 && out_chan.peak_time == '0 && !out_chan.saturated)
    else $error("zero curvature result carries nonzero peak fields");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.saturated |->
      out_chan.peak_value == 24'sh7FFFFF || out_chan.peak_value == -24'sh800000 ||
      out_chan.peak_time == 16'sh7FFF || out_chan.peak_time == -16'sh8000)
    else $error("saturated flag without a clipped peak field");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |-> !in_chan.ready)
    else $error("input accepted while the pipeline is stalled");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

endmodule

>>> rtl/qpf_coef.sv
module qpf_coef #(
  parameter int ADC_BITS = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  qpf_pkg::smp_t   smp [qpf_pkg::NSMP],
  output logic            v_r,
  output qpf_pkg::coef_t  coef_r
);

  localparam int SAMPLE_W = (ADC_BITS < qpf_pkg::SMP_W) ? ADC_BITS : qpf_pkg::SMP_W;
  localparam qpf_pkg::smp_t SMP_MASK = qpf_pkg::smp_t'((64'd1 << SAMPLE_W) - 64'd1);

  qpf_pkg::dot_t  s_ext [qpf_pkg::NSMP];
  qpf_pkg::dot_t  acc_a, acc_b, acc_c;
  qpf_pkg::coef_t coef_nxt;

  always_comb begin
    for (int i = 0; i < qpf_pkg::NSMP; i++) begin
      s_ext[i] = qpf_pkg::dot_t'({1'b0, smp[i] & SMP_MASK});
    end
  end

  // Constant weights turn into shift-add trees.
  always_comb begin
    acc_a = '0;
    acc_b = '0;
    acc_c = '0;
    for (int i = 0; i < qpf_pkg::NSMP; i++) begin
      acc_a = acc_a + s_ext[i] * qpf_pkg::W_A[i];
      acc_b = acc_b + s_ext[i] * qpf_pkg::W_B[i];
      acc_c = acc_c + s_ext[i] * qpf_pkg::W_C[i];
    end
    coef_nxt.a = acc_a[qpf_pkg::A_W-1:0];
    coef_nxt.b = acc_b[qpf_pkg::B_W-1:0];
    coef_nxt.c = acc_c[qpf_pkg::C_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef_r <= coef_nxt;
    end
  end

endmodule

>>> rtl/qpf_prod.sv
module qpf_prod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  qpf_pkg::coef_t               coef,
  output logic                         v4_r,
  output logic [qpf_pkg::UV_W-1:0]     uv_r,
  output logic [qpf_pkg::DV_W-1:0]     dv4_r,
  output logic [qpf_pkg::UT_W-1:0]     ut4_r,
  output logic [qpf_pkg::DT_W-1:0]     dt4_r,
  output qpf_pkg::side_t               side4_r
);

  localparam logic [qpf_pkg::DV_W-1:0] DEN4 = qpf_pkg::DV_W'(4 * qpf_pkg::FIT_DET);

  // Stage 2: products and magnitudes.
  logic signed [qpf_pkg::AC_W-1:0] ac_r, ac_nxt;
  logic signed [qpf_pkg::BB_W-1:0] bb_r, bb_nxt;
  logic [qpf_pkg::A_W-1:0]         a_abs;
  logic [qpf_pkg::B_W-1:0]         b_abs;
  logic [qpf_pkg::DT_W-1:0]        a_mag_r, a_mag_nxt;
  logic [qpf_pkg::BM_W-1:0]        b_mag_r, b_mag_nxt;
  logic                            a_neg_r, a_neg_nxt;
  logic                            neg_t_r, neg_t_nxt;
  logic                            flat_r, flat_nxt;
  qpf_pkg::a_t                     a2_r;
  logic                            v2_r;

  // Stage 3: scaled numerators and denominators.
  logic signed [qpf_pkg::NV_W-1:0] nv_r, nv_nxt;
  logic [qpf_pkg::DV_W-1:0]        dv_r, dv_nxt;
  logic [qpf_pkg::UT_W-1:0]        ut_r, ut_nxt;
  logic [qpf_pkg::DT_W-1:0]        dt_r;
  logic                            a_neg3_r, neg_t3_r, flat3_r;
  qpf_pkg::a_t                     a3_r;
  logic                            v3_r;

  // Stage 4: rounding bias folded into the value magnitude.
  logic [qpf_pkg::NV_W-1:0]        uv_full;
  logic [qpf_pkg::UV_W-1:0]        uv_nxt;
  logic [qpf_pkg::NV_W-1:0]        bias_v;
  logic                            nv_neg;
  qpf_pkg::side_t                  side4_nxt;

  always_comb begin
    a_neg_nxt = coef.a[qpf_pkg::A_W-1];
    a_abs     = a_neg_nxt ? (~coef.a + 1'b1) : coef.a;
    b_abs     = coef.b[qpf_pkg::B_W-1] ? (~coef.b + 1'b1) : coef.b;
    a_mag_nxt = a_abs[qpf_pkg::DT_W-1:0];
    b_mag_nxt = b_abs[qpf_pkg::BM_W-1:0];
    ac_nxt    = coef.a * coef.c;
    bb_nxt    = coef.b * coef.b;
    flat_nxt  = (coef.a == '0);
    // The time numerator is -128*B, negative when B is positive.
    neg_t_nxt = (!coef.b[qpf_pkg::B_W-1] && (coef.b != '0)) ^ a_neg_nxt;
  end

  always_comb begin
    nv_nxt = (qpf_pkg::NV_W'(ac_r) <<< (qpf_pkg::VAL_SH + 2))
           - (qpf_pkg::NV_W'(bb_r) <<< qpf_pkg::VAL_SH);
    dv_nxt = qpf_pkg::DV_W'(a_mag_r) * DEN4;
    ut_nxt = (qpf_pkg::UT_W'(b_mag_r) << qpf_pkg::TIME_SH)
           + qpf_pkg::UT_W'(a_mag_r >> 1);
  end

  always_comb begin
    nv_neg  = nv_r[qpf_pkg::NV_W-1];
    bias_v  = qpf_pkg::NV_W'(dv_r >> 1);
    uv_full = nv_neg ? (bias_v - nv_r) : (nv_r + bias_v);
    uv_nxt  = uv_full[qpf_pkg::UV_W-1:0];
    side4_nxt.flat  = flat3_r;
    side4_nxt.neg_v = nv_neg ^ a_neg3_r;
    side4_nxt.neg_t = neg_t3_r;
    side4_nxt.a     = a3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v2_r <= in_v;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac_r     <= ac_nxt;
      bb_r     <= bb_nxt;
      a_mag_r  <= a_mag_nxt;
      b_mag_r  <= b_mag_nxt;
      a_neg_r  <= a_neg_nxt;
      neg_t_r  <= neg_t_nxt;
      flat_r   <= flat_nxt;
      a2_r     <= coef.a;

      nv_r     <= nv_nxt;
      dv_r     <= dv_nxt;
      ut_r     <= ut_nxt;
      dt_r     <= a_mag_r;
      a_neg3_r <= a_neg_r;
      neg_t3_r <= neg_t_r;
      flat3_r  <= flat_r;
      a3_r     <= a2_r;

      uv_r     <= uv_nxt;
      dv4_r    <= dv_r;
      ut4_r    <= ut_r;
      dt4_r    <= dt_r;
      side4_r  <= side4_nxt;
    end
  end

endmodule

>>> rtl/qpf_div.sv
module qpf_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 22,
  parameter int Q_W   = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_v,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  localparam int REM_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [REM_W-1:0] rem_r [Q_W+1];
  logic [DEN_W-1:0] den_r [Q_W+1];
  logic [Q_W-1:0]   quo_r [Q_W+1];
  logic             ovf_r [Q_W+1];
  logic [Q_W:0]     v_r;
  logic             ovf_nxt;

  // A quotient that does not fit in Q_W bits is flagged up front; the
  // restoring steps below then only need Q_W subtractions.
  assign ovf_nxt = REM_W'(num) >= (REM_W'(den) << Q_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Q_W-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= REM_W'(num);
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= ovf_nxt;
    end
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_step
    localparam int K = Q_W - j;
    logic [REM_W-1:0] sub;
    logic [REM_W-1:0] rem_nxt;
    logic             ge;

    assign sub     = REM_W'(den_r[j-1]) << K;
    assign ge      = rem_r[j-1] >= sub;
    assign rem_nxt = ge ? (rem_r[j-1] - sub) : rem_r[j-1];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        den_r[j] <= den_r[j-1];
        quo_r[j] <= quo_r[j-1] | (Q_W'(ge) << K);
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign out_v = v_r[Q_W];
  assign quo   = quo_r[Q_W];
  assign ovf   = ovf_r[Q_W];

endmodule
